>>> src/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression holds at every clock edge outside reset.
`define EHC_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define EHC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define EHC_ASSERT(label, expr, msg)
`define EHC_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

>>> src/ehc_pkg.sv
// Constants, types and arithmetic helpers of the coordinate converter.
package ehc_pkg;

   localparam int ANGLE_BITS    = 32;
   localparam int FRACTION_BITS = 30;
   localparam int WIDE_BITS     = 64;
   localparam int CORDIC_STEPS  = FRACTION_BITS + 2;
   localparam int VAL_W         = FRACTION_BITS + 4;
   localparam int ROOT_REM_W    = 2 * FRACTION_BITS + 2;
   localparam int DIV_W         = VAL_W;

   // unit latencies in cycles
   localparam int ROT_LAT  = CORDIC_STEPS + 1;
   localparam int ROOT_LAT = FRACTION_BITS + 2;
   localparam int ASIN_LAT = CORDIC_STEPS + 1;
   localparam int DIV_LAT  = FRACTION_BITS + 2;
   localparam int Q_DLY    = 2 + DIV_LAT + ROOT_LAT;
   localparam int SX_DLY   = 2 * ROOT_LAT + 2 + DIV_LAT + ASIN_LAT;

   typedef logic signed [VAL_W-1:0]     value_type;
   typedef logic signed [WIDE_BITS-1:0] angle_type;

   localparam logic [63:0] ONE64     = 64'd1 << FRACTION_BITS;
   localparam value_type   FX_ONE    = value_type'(ONE64);
   localparam logic [63:0] GAIN_Q62  = 64'd2800459870029452932;
   localparam value_type   CORDIC_X0 = value_type'(GAIN_Q62 >> (62 - FRACTION_BITS));
   localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
   localparam angle_type   QUARTER_TURN = angle_type'(64'd1 << 62);
   localparam logic [WIDE_BITS-1:0] HALF_NARROW =
      WIDE_BITS'(64'd1 << (WIDE_BITS - ANGLE_BITS - 1));

   // shift-subtract division, elaboration time only
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] quo;
      int b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         quo = {quo[62:0], 1'b0};
         if (rem >= {1'b0, d}) begin
            rem    = rem - {1'b0, d};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // arctan(2^-idx) in turns, 2^64 to a turn
   function automatic logic [63:0] atan_entry(input int idx);
      logic [63:0]  rad;
      logic [63:0]  term;
      logic [63:0]  quo;
      logic [64:0]  rem;
      logic [127:0] num;
      int k;
      int b;
      rad = '0;
      if (idx == 0) begin
         rad = PI_Q60;
      end else begin
         for (k = 0; idx * (2 * k + 1) <= 62; k++) begin
            term = udiv64(64'd1 << (62 - idx * (2 * k + 1)), 64'(2 * k + 1));
            if (k[0]) rad = rad - term;
            else rad = rad + term;
         end
      end
      num = {64'd0, rad} << 61;
      rem = '0;
      quo = '0;
      for (b = 127; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         quo = {quo[62:0], 1'b0};
         if (rem >= {1'b0, PI_Q60}) begin
            rem    = rem - {1'b0, PI_Q60};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // fixed point product, magnitude rounded half away from zero
   function automatic value_type fx_mul(input value_type a, input value_type b);
      logic [VAL_W-1:0]   ua;
      logic [VAL_W-1:0]   ub;
      logic [2*VAL_W-1:0] prod;
      logic [2*VAL_W-1:0] rnd;
      value_type          r;
      logic               neg;
      neg  = a[VAL_W-1] ^ b[VAL_W-1];
      ua   = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
      ub   = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
      prod = (2*VAL_W)'(ua) * (2*VAL_W)'(ub);
      rnd  = prod + (2*VAL_W)'(ONE64 >> 1);
      r    = value_type'(rnd >> FRACTION_BITS);
      return neg ? -r : r;
   endfunction

endpackage

>>> src/ehc_rotate.sv
// Rotation CORDIC pipeline: sine and cosine of one binary angle.
module ehc_rotate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_vld,
   input  logic [ehc_pkg::WIDE_BITS-1:0]    in_angle,
   output logic                             out_vld,
   output ehc_pkg::value_type               out_sin,
   output ehc_pkg::value_type               out_cos
);
   import ehc_pkg::*;

   logic      vld_ff  [CORDIC_STEPS];
   value_type x_ff    [CORDIC_STEPS];
   value_type y_ff    [CORDIC_STEPS];
   angle_type z_ff    [CORDIC_STEPS];
   logic [1:0] quad_ff [CORDIC_STEPS];

   logic      out_vld_ff;
   value_type sin_ff, sin_in;
   value_type cos_ff, cos_in;

   genvar k;
   for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
      localparam angle_type ATAN = angle_type'(atan_entry(k));
      logic       vld_prev;
      value_type  x_prev, y_prev, x_in, y_in;
      angle_type  z_prev, z_in;
      logic [1:0] quad_prev;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign x_prev    = CORDIC_X0;
         assign y_prev    = '0;
         assign z_prev    = angle_type'({2'b00, in_angle[WIDE_BITS-3:0]});
         assign quad_prev = in_angle[WIDE_BITS-1:WIDE_BITS-2];
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign x_prev    = x_ff[k-1];
         assign y_prev    = y_ff[k-1];
         assign z_prev    = z_ff[k-1];
         assign quad_prev = quad_ff[k-1];
      end

      always_comb begin
         if (!z_prev[WIDE_BITS-1]) begin
            x_in = x_prev - (y_prev >>> k);
            y_in = y_prev + (x_prev >>> k);
            z_in = z_prev - ATAN;
         end else begin
            x_in = x_prev + (y_prev >>> k);
            y_in = y_prev - (x_prev >>> k);
            z_in = z_prev + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            z_ff[k]    <= z_in;
            quad_ff[k] <= quad_prev;
         end
      end
   end

   // quadrant fold
   always_comb begin
      unique case (quad_ff[CORDIC_STEPS-1])
         2'd0: begin
            cos_in = x_ff[CORDIC_STEPS-1];
            sin_in = y_ff[CORDIC_STEPS-1];
         end
         2'd1: begin
            cos_in = -y_ff[CORDIC_STEPS-1];
            sin_in = x_ff[CORDIC_STEPS-1];
         end
         2'd2: begin
            cos_in = -x_ff[CORDIC_STEPS-1];
            sin_in = -y_ff[CORDIC_STEPS-1];
         end
         default: begin
            cos_in = y_ff[CORDIC_STEPS-1];
            sin_in = -x_ff[CORDIC_STEPS-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign out_vld = out_vld_ff;
   assign out_sin = sin_ff;
   assign out_cos = cos_ff;

endmodule

>>> src/ehc_root.sv
// Digit-by-digit square root pipeline: floor(sqrt(1 - s*s)).
`include "assert_macros.svh"
module ehc_root (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_vld,
   input  ehc_pkg::value_type                  in_s,
   output logic                                out_vld,
   output ehc_pkg::value_type                  out_s,
   output logic [ehc_pkg::FRACTION_BITS:0]     out_root
);
   import ehc_pkg::*;

   localparam int NSTEP = FRACTION_BITS + 1;
   localparam logic [FRACTION_BITS+1:0] ONE_R = (FRACTION_BITS+2)'(ONE64);

   logic [FRACTION_BITS:0]   u;
   logic [FRACTION_BITS+1:0] lo_f, hi_f;
   logic [ROOT_REM_W-1:0]    v_in;

   logic                  v_vld_ff;
   logic [ROOT_REM_W-1:0] v_ff;
   value_type             s0_ff;

   logic                   vld_ff [NSTEP];
   logic [ROOT_REM_W-1:0]  rem_ff [NSTEP];
   logic [FRACTION_BITS:0] res_ff [NSTEP];
   value_type              s_ff   [NSTEP];

   always_comb begin
      u    = in_s[VAL_W-1] ? (FRACTION_BITS+1)'(-in_s) : (FRACTION_BITS+1)'(in_s);
      lo_f = ONE_R - {1'b0, u};
      hi_f = ONE_R + {1'b0, u};
      v_in = ROOT_REM_W'(lo_f) * ROOT_REM_W'(hi_f);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld_ff <= 1'b0;
      end else if (en) begin
         v_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff  <= v_in;
         s0_ff <= in_s;
      end
   end

   genvar j;
   for (j = 0; j < NSTEP; j++) begin : g_bit
      localparam int B = FRACTION_BITS - j;
      logic                   vld_prev;
      logic [ROOT_REM_W-1:0]  rem_prev, rem_in, trial;
      logic [FRACTION_BITS:0] res_prev, res_in;
      value_type              s_prev;

      if (j == 0) begin : g_first
         assign vld_prev = v_vld_ff;
         assign rem_prev = v_ff;
         assign res_prev = '0;
         assign s_prev   = s0_ff;
      end else begin : g_next
         assign vld_prev = vld_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
         assign s_prev   = s_ff[j-1];
      end

      always_comb begin
         trial  = (ROOT_REM_W'(res_prev) << (B + 1)) + (ROOT_REM_W'(1) << (2 * B));
         rem_in = rem_prev;
         res_in = res_prev;
         if (rem_prev >= trial) begin
            rem_in    = rem_prev - trial;
            res_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            res_ff[j] <= res_in;
            s_ff[j]   <= s_prev;
         end
      end
   end

   assign out_vld  = vld_ff[NSTEP-1];
   assign out_s    = s_ff[NSTEP-1];
   assign out_root = res_ff[NSTEP-1];

   `EHC_ASSERT_IMP(a_root_bound, out_vld, out_root <= (FRACTION_BITS+1)'(ONE64),
      "square root above one")

endmodule

>>> src/ehc_arcsin.sv
// Vectoring CORDIC pipeline: arcsine from a sine and its cosine root.
module ehc_arcsin (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_vld,
   input  ehc_pkg::value_type                in_s,
   input  logic [ehc_pkg::FRACTION_BITS:0]   in_root,
   output logic                              out_vld,
   output ehc_pkg::angle_type                out_angle
);
   import ehc_pkg::*;

   logic      vld_ff [CORDIC_STEPS];
   logic      pos_ff [CORDIC_STEPS];
   logic      neg_ff [CORDIC_STEPS];
   value_type x_ff   [CORDIC_STEPS];
   value_type y_ff   [CORDIC_STEPS];
   angle_type z_ff   [CORDIC_STEPS];

   logic      out_vld_ff;
   angle_type ang_ff, ang_in;

   genvar k;
   for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
      localparam angle_type ATAN = angle_type'(atan_entry(k));
      logic      vld_prev, pos_prev, neg_prev;
      value_type x_prev, y_prev, x_in, y_in;
      angle_type z_prev, z_in;

      if (k == 0) begin : g_first
         assign vld_prev = in_vld;
         assign pos_prev = in_s >= FX_ONE;
         assign neg_prev = in_s <= -FX_ONE;
         assign x_prev   = value_type'({{(VAL_W-FRACTION_BITS-1){1'b0}}, in_root});
         assign y_prev   = in_s;
         assign z_prev   = '0;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign pos_prev = pos_ff[k-1];
         assign neg_prev = neg_ff[k-1];
         assign x_prev   = x_ff[k-1];
         assign y_prev   = y_ff[k-1];
         assign z_prev   = z_ff[k-1];
      end

      always_comb begin
         if (!y_prev[VAL_W-1]) begin
            x_in = x_prev + (y_prev >>> k);
            y_in = y_prev - (x_prev >>> k);
            z_in = z_prev + ATAN;
         end else begin
            x_in = x_prev - (y_prev >>> k);
            y_in = y_prev + (x_prev >>> k);
            z_in = z_prev - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pos_ff[k] <= pos_prev;
            neg_ff[k] <= neg_prev;
            x_ff[k]   <= x_in;
            y_ff[k]   <= y_in;
            z_ff[k]   <= z_in;
         end
      end
   end

   // saturated inputs map to exactly +-quarter turn; otherwise clamp
   always_comb begin
      priority if (pos_ff[CORDIC_STEPS-1]) begin
         ang_in = QUARTER_TURN;
      end else if (neg_ff[CORDIC_STEPS-1]) begin
         ang_in = -QUARTER_TURN;
      end else if (z_ff[CORDIC_STEPS-1] > QUARTER_TURN) begin
         ang_in = QUARTER_TURN;
      end else if (z_ff[CORDIC_STEPS-1] < -QUARTER_TURN) begin
         ang_in = -QUARTER_TURN;
      end else begin
         ang_in = z_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
      end
   end

   assign out_vld   = out_vld_ff;
   assign out_angle = ang_ff;

endmodule

>>> src/ehc_divide.sv
// Restoring divider pipeline: signed quotient num/den, saturated to +-1.
`include "assert_macros.svh"
module ehc_divide (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  ehc_pkg::value_type in_num,
   input  ehc_pkg::value_type in_den,
   output logic               out_vld,
   output ehc_pkg::value_type out_cp
);
   import ehc_pkg::*;

   logic [DIV_W-1:0] mag_in;

   logic             v0_ff;
   logic [DIV_W-1:0] rem0_ff, den0_ff;
   logic             full0_ff, neg0_ff;

   logic                     vld_ff  [FRACTION_BITS];
   logic [DIV_W-1:0]         rem_ff  [FRACTION_BITS];
   logic [DIV_W-1:0]         den_ff  [FRACTION_BITS];
   logic [FRACTION_BITS-1:0] quo_ff  [FRACTION_BITS];
   logic                     full_ff [FRACTION_BITS];
   logic                     neg_ff  [FRACTION_BITS];

   logic      out_vld_ff;
   value_type cp_ff, cp_in, qv;

   assign mag_in = in_num[VAL_W-1] ? DIV_W'(-in_num) : DIV_W'(in_num);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem0_ff  <= mag_in;
         den0_ff  <= DIV_W'(in_den);
         full0_ff <= mag_in >= DIV_W'(in_den);
         neg0_ff  <= in_num[VAL_W-1];
      end
   end

   genvar j;
   for (j = 0; j < FRACTION_BITS; j++) begin : g_step
      logic                     vld_prev, full_prev, neg_prev;
      logic [DIV_W-1:0]         rem_prev, den_prev, rem2, rem_in;
      logic [FRACTION_BITS-1:0] quo_prev, quo_in;

      if (j == 0) begin : g_first
         assign vld_prev  = v0_ff;
         assign rem_prev  = rem0_ff;
         assign den_prev  = den0_ff;
         assign quo_prev  = '0;
         assign full_prev = full0_ff;
         assign neg_prev  = neg0_ff;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign full_prev = full_ff[j-1];
         assign neg_prev  = neg_ff[j-1];
      end

      always_comb begin
         rem2   = rem_prev << 1;
         quo_in = quo_prev << 1;
         rem_in = rem2;
         if (rem2 >= den_prev) begin
            rem_in    = rem2 - den_prev;
            quo_in[0] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_prev;
            quo_ff[j]  <= quo_in;
            full_ff[j] <= full_prev;
            neg_ff[j]  <= neg_prev;
         end
      end
   end

   always_comb begin
      qv    = full_ff[FRACTION_BITS-1] ? FX_ONE :
              value_type'({{(VAL_W-FRACTION_BITS){1'b0}}, quo_ff[FRACTION_BITS-1]});
      cp_in = neg_ff[FRACTION_BITS-1] ? -qv : qv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[FRACTION_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cp_ff <= cp_in;
      end
   end

   assign out_vld = out_vld_ff;
   assign out_cp  = cp_ff;

   `EHC_ASSERT_IMP(a_cp_bound, out_vld, (out_cp <= FX_ONE) && (out_cp >= -FX_ONE),
      "quotient outside plus or minus one")

endmodule

>>> src/equatorial_horizontal_convert.sv
// Top level: equatorial / horizontal coordinate converter pipeline.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_turn_angle, req_tilt_angle
//   rsp       out        rsp_valid/rsp_ready   rsp_out_turn_angle, rsp_out_tilt_angle
//   csr       in         csr_valid/csr_ready   csr_site_latitude
//
// One item per clock enters while no result is held at the output; each result
// passes the rotation CORDIC, three multiply stages, a square root, two divide
// prep stages, the divider, a second square root, the arcsine and output register.
// The latency is set by the bit-per-stage CORDIC, root and divider chains.
// Reset is synchronous and clears every valid bit and the latitude; both
// ready outputs are low while reset is high.
// A held result stalls the whole pipeline in place; req_ready drops with it.
`include "assert_macros.svh"
module equatorial_horizontal_convert (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic        [ehc_pkg::ANGLE_BITS-1:0] req_turn_angle,
   input  logic signed [ehc_pkg::ANGLE_BITS-1:0] req_tilt_angle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [ehc_pkg::ANGLE_BITS-1:0] rsp_out_turn_angle,
   output logic signed [ehc_pkg::ANGLE_BITS-1:0] rsp_out_tilt_angle,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic signed [ehc_pkg::ANGLE_BITS-1:0] csr_site_latitude
);
   import ehc_pkg::*;

   localparam int PAD = WIDE_BITS - ANGLE_BITS;

   typedef struct packed {
      value_type sy;
      value_type sphi;
      value_type cphi;
   } side_type;

   // pipeline advances unless a result is held at the output
   logic en;
   logic in_xfer;

   logic signed [ANGLE_BITS-1:0] lat_ff;

   // sine / cosine lanes
   logic      vld_lat, vld_tilt, vld_turn;
   value_type sphi, cphi, sy, cy, sx, cx;

   // product stages
   logic      m1_vld_ff, m2_vld_ff, m3_vld_ff;
   value_type p1_m1_ff, p2_m1_ff, p1_m2_ff, p3_m2_ff, sq_m3_ff, sq_sum;
   side_type  side_m1_ff, side_m2_ff, side_m3_ff;
   logic      sxpos_m1_ff, sxpos_m2_ff, sxpos_m3_ff;

   // first root, elevation arcsine
   logic                   vld_r1, vld_q;
   value_type              sq_r1;
   logic [FRACTION_BITS:0] rq_r1;
   angle_type              q_ang;
   side_type               side_dly_ff [ROOT_LAT];

   // divider prep
   logic      d1_vld_ff, d2_vld_ff;
   value_type dprod_d1_ff, sp_d1_ff, sy_d1_ff, num_d2_ff, den_d2_ff;

   // quotient path
   logic                   vld_div, vld_r2, vld_a2;
   value_type              cp_div, cp_r2;
   logic [FRACTION_BITS:0] rcp_r2;
   angle_type              a_cp;

   // alignment lines
   logic      qv_dly_ff [Q_DLY];
   angle_type qa_dly_ff [Q_DLY];
   logic      sx_dly_ff [SX_DLY];

   // output register
   logic                         out_vld_ff;
   logic [ANGLE_BITS-1:0]        turn_ff, turn_in;
   logic signed [ANGLE_BITS-1:0] tilt_ff, tilt_in;
   logic [WIDE_BITS-1:0]         p_pre, p_val, p_rnd, q_rnd;

   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en && !reset;
   assign in_xfer   = req_valid && req_ready;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         lat_ff <= csr_site_latitude;
      end
   end

   ehc_rotate u_rot_lat (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (in_xfer),
      .in_angle ({lat_ff, PAD'(0)}),
      .out_vld  (vld_lat),
      .out_sin  (sphi),
      .out_cos  (cphi)
   );

   ehc_rotate u_rot_tilt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (in_xfer),
      .in_angle ({req_tilt_angle, PAD'(0)}),
      .out_vld  (vld_tilt),
      .out_sin  (sy),
      .out_cos  (cy)
   );

   ehc_rotate u_rot_turn (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (in_xfer),
      .in_angle ({req_turn_angle, PAD'(0)}),
      .out_vld  (vld_turn),
      .out_sin  (sx),
      .out_cos  (cx)
   );

   // sq = sin(tilt)sin(lat) + cos(tilt)cos(turn)cos(lat), saturated
   assign sq_sum = p1_m2_ff + p3_m2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= vld_lat;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
         d1_vld_ff <= vld_r1;
         d2_vld_ff <= d1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_m1_ff    <= fx_mul(sy, sphi);
         p2_m1_ff    <= fx_mul(cy, cx);
         side_m1_ff  <= '{sy: sy, sphi: sphi, cphi: cphi};
         sxpos_m1_ff <= !sx[VAL_W-1] && (sx != '0);

         p1_m2_ff    <= p1_m1_ff;
         p3_m2_ff    <= fx_mul(p2_m1_ff, side_m1_ff.cphi);
         side_m2_ff  <= side_m1_ff;
         sxpos_m2_ff <= sxpos_m1_ff;

         priority if (sq_sum > FX_ONE) begin
            sq_m3_ff <= FX_ONE;
         end else if (sq_sum < -FX_ONE) begin
            sq_m3_ff <= -FX_ONE;
         end else begin
            sq_m3_ff <= sq_sum;
         end
         side_m3_ff  <= side_m2_ff;
         sxpos_m3_ff <= sxpos_m2_ff;
      end
   end

   ehc_root u_root_q (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (m3_vld_ff),
      .in_s     (sq_m3_ff),
      .out_vld  (vld_r1),
      .out_s    (sq_r1),
      .out_root (rq_r1)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_dly_ff[0] <= side_m3_ff;
         for (int k = 1; k < ROOT_LAT; k++) begin
            side_dly_ff[k] <= side_dly_ff[k-1];
         end
      end
   end

   ehc_arcsin u_asin_q (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (vld_r1),
      .in_s      (sq_r1),
      .in_root   (rq_r1),
      .out_vld   (vld_q),
      .out_angle (q_ang)
   );

   // cp = (sin(tilt) - sin(lat)sq) / max(cos(lat)cos(q), one LSB)
   always_ff @(posedge clock) begin
      if (en) begin
         dprod_d1_ff <= fx_mul(side_dly_ff[ROOT_LAT-1].cphi,
                               value_type'({{(VAL_W-FRACTION_BITS-1){1'b0}}, rq_r1}));
         sp_d1_ff    <= fx_mul(side_dly_ff[ROOT_LAT-1].sphi, sq_r1);
         sy_d1_ff    <= side_dly_ff[ROOT_LAT-1].sy;

         num_d2_ff   <= sy_d1_ff - sp_d1_ff;
         den_d2_ff   <= (dprod_d1_ff < value_type'(1)) ? value_type'(1) : dprod_d1_ff;
      end
   end

   ehc_divide u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (d2_vld_ff),
      .in_num  (num_d2_ff),
      .in_den  (den_d2_ff),
      .out_vld (vld_div),
      .out_cp  (cp_div)
   );

   ehc_root u_root_p (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld_div),
      .in_s     (cp_div),
      .out_vld  (vld_r2),
      .out_s    (cp_r2),
      .out_root (rcp_r2)
   );

   ehc_arcsin u_asin_p (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (vld_r2),
      .in_s      (cp_r2),
      .in_root   (rcp_r2),
      .out_vld   (vld_a2),
      .out_angle (a_cp)
   );

   // hold q and the sin(turn) sign until the quotient path catches up
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_DLY; k++) begin
            qv_dly_ff[k] <= 1'b0;
         end
      end else if (en) begin
         qv_dly_ff[0] <= vld_q;
         for (int k = 1; k < Q_DLY; k++) begin
            qv_dly_ff[k] <= qv_dly_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qa_dly_ff[0] <= q_ang;
         sx_dly_ff[0] <= sxpos_m3_ff;
         for (int k = 1; k < Q_DLY; k++) begin
            qa_dly_ff[k] <= qa_dly_ff[k-1];
         end
         for (int k = 1; k < SX_DLY; k++) begin
            sx_dly_ff[k] <= sx_dly_ff[k-1];
         end
      end
   end

   // p = quarter turn - asin(cp), mirrored when sin(turn) > 0; round to port width
   always_comb begin
      p_pre   = WIDE_BITS'(QUARTER_TURN) - WIDE_BITS'(a_cp);
      p_val   = sx_dly_ff[SX_DLY-1] ? (WIDE_BITS'(0) - p_pre) : p_pre;
      p_rnd   = p_val + HALF_NARROW;
      q_rnd   = WIDE_BITS'(qa_dly_ff[Q_DLY-1]) + HALF_NARROW;
      turn_in = p_rnd[WIDE_BITS-1 -: ANGLE_BITS];
      tilt_in = q_rnd[WIDE_BITS-1 -: ANGLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_a2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         turn_ff <= turn_in;
         tilt_ff <= tilt_in;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_out_turn_angle = turn_ff;
   assign rsp_out_tilt_angle = tilt_ff;

   `EHC_ASSERT(a_lanes_aligned, (vld_lat == vld_tilt) && (vld_tilt == vld_turn),
      "sine lanes out of step")
   `EHC_ASSERT(a_q_aligned, qv_dly_ff[Q_DLY-1] == vld_a2,
      "elevation path out of step with quotient path")

endmodule
